// File: rtl/core/quaternion_arithmetic_unit_core_macros.svh
// ---------------------------------------------------------------------------
// Quaternion unit assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define QAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define QAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/qau_pkg.sv
// ---------------------------------------------------------------------------
// Quaternion unit package
// Operation codes, status codes and the types shared by the unit's modules.
// ---------------------------------------------------------------------------
package qau_pkg;

  // Operation selector codes.
  typedef enum logic [2:0] {
    OP_MUL  = 3'd0,
    OP_VEC  = 3'd1,
    OP_CONJ = 3'd2,
    OP_NORM = 3'd3,
    OP_MAT  = 3'd4
  } op_e;

  // Width of one component field on the ports.
  localparam int unsigned FieldW = 32;

  // Depth of the request queue between front and back.
  localparam int unsigned QueueDepth = 2;

  // Result status codes.
  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusZero = 2'd1;
  localparam logic [1:0] StatusSat  = 2'd2;

  typedef logic [FieldW-1:0] field_t;

  // One queued request.
  typedef struct packed {
    op_e             op;
    field_t [3:0]    a;
    field_t [3:0]    b;
  } item_t;

  // Control from the back end to the normalize unit.
  typedef struct packed {
    logic start;
    logic ack;
  } norm_ctl_t;

  // Status from the normalize unit to the back end.
  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } norm_stat_t;

endpackage

// File: rtl/core/qau_front.sv
// ---------------------------------------------------------------------------
// Quaternion unit front end
// Accepts requests, drops unknown operation codes and queues the rest.
// ---------------------------------------------------------------------------
`include "quaternion_arithmetic_unit_core_macros.svh"

module qau_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [2:0]                 func_i,
  input  qau_pkg::field_t [3:0]      a_i,
  input  qau_pkg::field_t [3:0]      b_i,
  output logic                       head_valid_o,
  output qau_pkg::item_t             head_o,
  input  logic                       pop_i
);

  localparam int unsigned Depth = qau_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  qau_pkg::item_t   mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             known;
  logic             push;

  // Classify the request: codes past the matrix operation give no result.
  assign known  = (func_i <= 3'(qau_pkg::OP_MAT));
  assign busy_o = (count_q == CntW'(Depth));
  assign push   = start_i && !busy_o && known;

  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{op: qau_pkg::op_e'(func_i), a: a_i, b: b_i};
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `QAU_ASSERT(a_fifo_no_underflow, pop_i |-> count_q != '0, "queue popped while empty")

endmodule

// File: rtl/core/qau_norm.sv
// ---------------------------------------------------------------------------
// Quaternion unit normalize engine
// Sum of squares, bit-serial square root and one-bit-per-cycle reciprocal.
// ---------------------------------------------------------------------------
`include "quaternion_arithmetic_unit_core_macros.svh"

module qau_norm #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  qau_pkg::norm_ctl_t         ctl_i,
  input  qau_pkg::item_t             item_i,
  output qau_pkg::norm_stat_t        stat_o,
  output qau_pkg::field_t [3:0]      a_o,
  output logic [2*FRAC_BITS:0]       recip_o
);

  localparam int unsigned CW   = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int unsigned QW   = 2 * CW;
  localparam int unsigned MW   = CW + 1;
  localparam int unsigned RemW = MW + 1;
  localparam int unsigned RW   = 2 * FRAC_BITS + 1;
  localparam int unsigned CntW = $clog2(RW);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SSqr  = 3'd1;
  localparam logic [2:0] SAcc  = 3'd2;
  localparam logic [2:0] SRoot = 3'd3;
  localparam logic [2:0] SFix  = 3'd4;
  localparam logic [2:0] SDiv  = 3'd5;
  localparam logic [2:0] SDone = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [CntW-1:0]       cnt_q;
  logic                  zero_q;
  qau_pkg::field_t [3:0] a_q;
  logic [QW-1:0]         sq_q [4];
  logic [QW-1:0]         rq_q, root_q, bit_q;
  logic [3:0]            lo_q;
  logic [MW-1:0]         m_q;
  logic [RemW-1:0]       dr_q;
  logic [RW-1:0]         quo_q;

  logic signed [CW-1:0]  comp [4];
  logic [QW-1:0]         sq [4];
  logic [QW-1:0]         qsum, trial;
  logic [3:0]            lsum;
  logic [QW+2:0]         fix_lhs, fix_rhs;
  logic                  fix_up;
  logic [MW-1:0]         m_new;
  logic                  nbit;
  logic [RemW-1:0]       shifted;
  logic                  ge;

  // Squares and their split sums; the low two bits are kept apart.
  always_comb begin
    qsum = '0;
    lsum = '0;
    for (int k = 0; k < 4; k++) begin
      comp[k] = signed'(a_q[k][CW-1:0]);
      sq[k]   = QW'(QW'(comp[k]) * QW'(comp[k]));
      qsum    = qsum + (sq_q[k] >> 2);
      lsum    = lsum + 4'(sq_q[k][1:0]);
    end
  end

  // Square root step and the final odd-root correction.
  always_comb begin
    trial   = root_q + bit_q;
    fix_lhs = (QW+3)'({rq_q, 2'b00}) + (QW+3)'(lo_q);
    fix_rhs = (QW+3)'({root_q, 2'b00}) + (QW+3)'(1);
    fix_up  = (fix_lhs >= fix_rhs);
    m_new   = MW'({root_q[CW-1:0], 1'b0}) + MW'(fix_up);
  end

  // Restoring divider step; the dividend has a single set bit at the top.
  always_comb begin
    nbit    = (cnt_q == CntW'(RW - 1));
    shifted = {dr_q[RemW-2:0], nbit};
    ge      = (shifted >= RemW'(m_q));
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (ctl_i.start) state_d = SSqr;
      SSqr:  state_d = SAcc;
      SAcc: begin
        state_d = (qsum == '0 && lsum == '0) ? SDone : SRoot;
      end
      SRoot: if (bit_q == QW'(1)) state_d = SFix;
      SFix:  state_d = SDiv;
      SDiv:  if (cnt_q == '0) state_d = SDone;
      SDone: if (ctl_i.ack) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == SAcc) begin
        zero_q <= (qsum == '0 && lsum == '0);
      end
      if (state_q == SFix) begin
        cnt_q <= CntW'(RW - 1);
      end else if (state_q == SDiv) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Datapath registers; the quotient is cleared so a zero magnitude scales by zero.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      SIdle: if (ctl_i.start) a_q <= item_i.a;
      SSqr: begin
        for (int k = 0; k < 4; k++) sq_q[k] <= sq[k];
      end
      SAcc: begin
        rq_q   <= qsum;
        lo_q   <= lsum;
        root_q <= '0;
        bit_q  <= QW'(1) << (QW - 2);
        quo_q  <= '0;
      end
      SRoot: begin
        if (rq_q >= trial) begin
          rq_q   <= rq_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      SFix: begin
        m_q   <= m_new;
        dr_q  <= '0;
        quo_q <= '0;
      end
      SDiv: begin
        dr_q  <= ge ? shifted - RemW'(m_q) : shifted;
        quo_q <= {quo_q[RW-2:0], ge};
      end
      default: ;
    endcase
  end

  assign stat_o  = '{busy: (state_q != SIdle), done: (state_q == SDone), zero: zero_q};
  assign a_o     = a_q;
  assign recip_o = quo_q;

  `QAU_ASSERT(a_norm_ack_done, ctl_i.ack |-> state_q == SDone, "normalize ack while not done")

endmodule

// File: rtl/core/qau_back.sv
// ---------------------------------------------------------------------------
// Quaternion unit back end
// Multiplier stage, then sum, rounding and saturation into the result register.
// ---------------------------------------------------------------------------
`include "quaternion_arithmetic_unit_core_macros.svh"

module qau_back #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  qau_pkg::item_t             head_i,
  output logic                       pop_o,
  output qau_pkg::norm_ctl_t         norm_ctl_o,
  input  qau_pkg::norm_stat_t        norm_stat_i,
  input  qau_pkg::field_t [3:0]      norm_a_i,
  input  logic [2*FRAC_BITS:0]       norm_recip_i,
  output logic                       res_valid_o,
  output qau_pkg::field_t [3:0]      res_o,
  output logic [1:0]                 row_index_o,
  output logic                       last_o,
  output logic [1:0]                 status_o
);

  localparam int unsigned CW = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int unsigned RW = 2 * FRAC_BITS + 1;
  localparam int unsigned BW = ((CW > RW) ? CW : RW) + 1;
  localparam int unsigned PW = CW + BW;
  localparam int unsigned SW = PW + 3;
  localparam int unsigned FW = qau_pkg::FieldW;

  localparam logic signed [SW-1:0] One2  = SW'(1) <<< (2 * FRAC_BITS - 1);
  localparam logic signed [SW-1:0] HalfF = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] HalfM = SW'(1) <<< (FRAC_BITS - 2);
  localparam logic signed [SW-1:0] SatHi = (SW'(1) <<< (CW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SatLo = -(SW'(1) <<< (CW - 1));

  // Multiplier stage registers.
  logic                   m_valid_q;
  qau_pkg::op_e           m_op_q;
  logic                   m_zero_q;
  logic [1:0]             m_row_q;
  logic signed [CW-1:0]   m_a_q [4];
  logic signed [PW-1:0]   m_prod_q [4][4];

  // Result register.
  logic                   res_valid_q;
  qau_pkg::field_t [3:0]  res_q;
  logic [1:0]             row_q;
  logic                   last_q;
  logic [1:0]             status_q;

  logic                   m_done, m_load;
  logic                   take_norm, take_head, start_norm;
  qau_pkg::op_e           src_op;
  qau_pkg::field_t [3:0]  src_a, src_b;
  logic signed [CW-1:0]   ca [4];
  logic signed [BW-1:0]   cax [4], cbx [4], rcx;
  logic signed [CW-1:0]   ma [4][4];
  logic signed [BW-1:0]   mb [4][4];
  logic signed [PW-1:0]   prod [4][4];

  // Source selection: a finished normalize goes first and holds the queue.
  assign m_done     = m_valid_q && (m_op_q != qau_pkg::OP_MAT || m_row_q == 2'd3);
  assign m_load     = !m_valid_q || m_done;
  assign take_norm  = norm_stat_i.done && m_load;
  assign take_head  = !norm_stat_i.busy && head_valid_i &&
                      (head_i.op != qau_pkg::OP_NORM) && m_load;
  assign start_norm = !norm_stat_i.busy && head_valid_i && (head_i.op == qau_pkg::OP_NORM);
  assign pop_o      = take_head || start_norm;
  assign norm_ctl_o = '{start: start_norm, ack: take_norm};

  assign src_op = take_norm ? qau_pkg::OP_NORM : head_i.op;
  assign src_a  = take_norm ? norm_a_i : head_i.a;
  assign src_b  = head_i.b;

  // Operand extension.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ca[k]  = signed'(src_a[k][CW-1:0]);
      cax[k] = BW'(ca[k]);
      cbx[k] = BW'(signed'(src_b[k][CW-1:0]));
    end
    if (src_op == qau_pkg::OP_VEC) cbx[0] = '0;
    rcx = BW'(signed'({1'b0, norm_recip_i}));
  end

  // Operand routing to the sixteen multipliers.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++) begin
        ma[k][i] = '0;
        mb[k][i] = '0;
      end
    end
    unique case (src_op)
      qau_pkg::OP_MUL, qau_pkg::OP_VEC: begin
        ma[0][0] = ca[0]; mb[0][0] = cbx[0];
        ma[0][1] = ca[1]; mb[0][1] = cbx[1];
        ma[0][2] = ca[2]; mb[0][2] = cbx[2];
        ma[0][3] = ca[3]; mb[0][3] = cbx[3];
        ma[1][0] = ca[1]; mb[1][0] = cbx[0];
        ma[1][1] = ca[0]; mb[1][1] = cbx[1];
        ma[1][2] = ca[2]; mb[1][2] = cbx[3];
        ma[1][3] = ca[3]; mb[1][3] = cbx[2];
        ma[2][0] = ca[2]; mb[2][0] = cbx[0];
        ma[2][1] = ca[0]; mb[2][1] = cbx[2];
        ma[2][2] = ca[3]; mb[2][2] = cbx[1];
        ma[2][3] = ca[1]; mb[2][3] = cbx[3];
        ma[3][0] = ca[3]; mb[3][0] = cbx[0];
        ma[3][1] = ca[0]; mb[3][1] = cbx[3];
        ma[3][2] = ca[1]; mb[3][2] = cbx[2];
        ma[3][3] = ca[2]; mb[3][3] = cbx[1];
      end
      qau_pkg::OP_NORM: begin
        for (int k = 0; k < 4; k++) begin
          ma[k][0] = ca[k];
          mb[k][0] = rcx;
        end
      end
      qau_pkg::OP_MAT: begin
        // Squares in row 0, cross terms in rows 1 and 2.
        ma[0][0] = ca[2]; mb[0][0] = cax[2];
        ma[0][1] = ca[3]; mb[0][1] = cax[3];
        ma[0][2] = ca[1]; mb[0][2] = cax[1];
        ma[1][0] = ca[1]; mb[1][0] = cax[2];
        ma[1][1] = ca[0]; mb[1][1] = cax[3];
        ma[1][2] = ca[1]; mb[1][2] = cax[3];
        ma[1][3] = ca[0]; mb[1][3] = cax[2];
        ma[2][0] = ca[2]; mb[2][0] = cax[3];
        ma[2][1] = ca[0]; mb[2][1] = cax[1];
      end
      default: ;
    endcase
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++) begin
        prod[k][i] = PW'(ma[k][i]) * PW'(mb[k][i]);
      end
    end
  end

  // Multiplier stage; a matrix request stays for four rows.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_row_q   <= '0;
    end else if (m_load) begin
      m_valid_q <= take_norm || take_head;
      m_row_q   <= '0;
    end else begin
      m_row_q   <= m_row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_op_q   <= src_op;
      m_zero_q <= take_norm && norm_stat_i.zero;
      for (int k = 0; k < 4; k++) begin
        m_a_q[k] <= ca[k];
        for (int i = 0; i < 4; i++) m_prod_q[k][i] <= prod[k][i];
      end
    end
  end

  logic signed [SW-1:0] pe [4][4];
  logic signed [SW-1:0] term [4][4];
  logic signed [SW-1:0] acc [4];
  logic signed [SW-1:0] val [4];
  logic signed [CW-1:0] lane [4];
  logic [3:0]           lane_sat;
  logic                 sh_full;
  qau_pkg::field_t [3:0] res_d;
  logic [1:0]           status_d;

  // Term selection per output lane.
  always_comb begin
    sh_full = 1'b1;
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++) begin
        pe[k][i]   = SW'(m_prod_q[k][i]);
        term[k][i] = '0;
      end
    end
    unique case (m_op_q)
      qau_pkg::OP_MUL, qau_pkg::OP_VEC: begin
        term[0][0] = pe[0][0];
        term[0][1] = -pe[0][1];
        term[0][2] = -pe[0][2];
        term[0][3] = -pe[0][3];
        for (int k = 1; k < 4; k++) begin
          term[k][0] = pe[k][0];
          term[k][1] = pe[k][1];
          term[k][2] = pe[k][2];
          term[k][3] = -pe[k][3];
        end
      end
      qau_pkg::OP_NORM: begin
        for (int k = 0; k < 4; k++) term[k][0] = pe[k][0];
      end
      qau_pkg::OP_MAT: begin
        sh_full = 1'b0;
        unique case (m_row_q)
          2'd0: begin
            term[0][0] = One2;     term[0][1] = -pe[0][0]; term[0][2] = -pe[0][1];
            term[1][0] = pe[1][0]; term[1][1] = -pe[1][1];
            term[2][0] = pe[1][2]; term[2][1] = pe[1][3];
          end
          2'd1: begin
            term[0][0] = pe[1][0]; term[0][1] = pe[1][1];
            term[1][0] = One2;     term[1][1] = -pe[0][2]; term[1][2] = -pe[0][1];
            term[2][0] = pe[2][0]; term[2][1] = -pe[2][1];
          end
          2'd2: begin
            term[0][0] = pe[1][2]; term[0][1] = -pe[1][3];
            term[1][0] = pe[2][0]; term[1][1] = pe[2][1];
            term[2][0] = One2;     term[2][1] = -pe[0][2]; term[2][2] = -pe[0][0];
          end
          default: begin
            // Last row: the one on the diagonal.
            term[3][0] = One2;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Sum and round half up, or negate for a conjugate; then saturate.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      acc[j] = term[j][0] + term[j][1] + term[j][2] + term[j][3] +
               (sh_full ? HalfF : HalfM);
      val[j] = sh_full ? (acc[j] >>> FRAC_BITS) : (acc[j] >>> (FRAC_BITS - 1));
      if (m_op_q == qau_pkg::OP_CONJ) begin
        val[j] = (j == 0) ? SW'(m_a_q[j]) : -SW'(m_a_q[j]);
      end
      lane_sat[j] = 1'b0;
      if (val[j] > SatHi) begin
        val[j]      = SatHi;
        lane_sat[j] = 1'b1;
      end else if (val[j] < SatLo) begin
        val[j]      = SatLo;
        lane_sat[j] = 1'b1;
      end
      lane[j]  = val[j][CW-1:0];
      res_d[j] = FW'(lane[j]);
    end
    priority if (m_zero_q) begin
      status_d = qau_pkg::StatusZero;
    end else if (lane_sat != '0) begin
      status_d = qau_pkg::StatusSat;
    end else begin
      status_d = qau_pkg::StatusOk;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    row_q    <= (m_op_q == qau_pkg::OP_MAT) ? m_row_q : 2'd0;
    last_q   <= m_done;
    status_q <= status_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign row_index_o = row_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

  `QAU_ASSERT_NEXT(a_mat_rows, m_valid_q && m_op_q == qau_pkg::OP_MAT && m_row_q != 2'd3, m_valid_q && m_op_q == qau_pkg::OP_MAT && m_row_q == $past(m_row_q) + 2'd1, "matrix rows out of sequence")
  `QAU_ASSERT(a_last_row, res_valid_q && last_q |-> row_q == 2'd0 || row_q == 2'd3, "last result on a middle matrix row")

endmodule

// File: rtl/core/quaternion_arithmetic_unit_core.sv
// ---------------------------------------------------------------------------
// Quaternion arithmetic unit
// Fixed-point Hamilton product, vector product, conjugate, normalize and
// rotation matrix on Q(WORD_BITS-FRAC_BITS).FRAC_BITS components.
// ---------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; busy_o rises only
// when the two-entry request queue is full. Product, vector product and
// conjugate requests go through at one per cycle while no matrix or normalize
// request holds the multiplier stage, passing the request queue, the
// multiplier stage and the result register. A matrix request occupies the
// multiplier stage for four rows, giving four row results on consecutive
// cycles. A normalize request runs in the iterative normalize engine through
// the bit-serial square root and the one-bit-per-cycle reciprocal divider;
// requests queued behind it wait. Results are shown for one cycle under
// res_valid_o and cannot be held off by the receiver.
module quaternion_arithmetic_unit_core #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  func_i,
  input  logic [31:0] a_w_i,
  input  logic [31:0] a_x_i,
  input  logic [31:0] a_y_i,
  input  logic [31:0] a_z_i,
  input  logic [31:0] b_w_i,
  input  logic [31:0] b_x_i,
  input  logic [31:0] b_y_i,
  input  logic [31:0] b_z_i,
  output logic        res_valid_o,
  output logic [31:0] res_0_o,
  output logic [31:0] res_1_o,
  output logic [31:0] res_2_o,
  output logic [31:0] res_3_o,
  output logic [1:0]  row_index_o,
  output logic        last_o,
  output logic [1:0]  status_o
);

  qau_pkg::field_t [3:0]  a_in, b_in, norm_a, res;
  logic                   head_valid, pop;
  qau_pkg::item_t         head;
  qau_pkg::norm_ctl_t     norm_ctl;
  qau_pkg::norm_stat_t    norm_stat;
  logic [2*FRAC_BITS:0]   norm_recip;

  // Gather the request components.
  assign a_in = {a_z_i, a_y_i, a_x_i, a_w_i};
  assign b_in = {b_z_i, b_y_i, b_x_i, b_w_i};

  qau_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .a_i          (a_in),
    .b_i          (b_in),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  qau_norm #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (norm_ctl),
    .item_i  (head),
    .stat_o  (norm_stat),
    .a_o     (norm_a),
    .recip_o (norm_recip)
  );

  qau_back #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .norm_ctl_o   (norm_ctl),
    .norm_stat_i  (norm_stat),
    .norm_a_i     (norm_a),
    .norm_recip_i (norm_recip),
    .res_valid_o  (res_valid_o),
    .res_o        (res),
    .row_index_o  (row_index_o),
    .last_o       (last_o),
    .status_o     (status_o)
  );

  assign res_0_o = res[0];
  assign res_1_o = res[1];
  assign res_2_o = res[2];
  assign res_3_o = res[3];

endmodule

// File: bench/testbench.sv
// ---------------------------------------------------------------------------
// Quaternion unit testbench
// Drives product, vector product, conjugate, normalize, matrix and unknown-code
// requests, directed then in random bursts, predicts every result in fixed
// point and checks each one field by field as it appears under res_valid_o.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned Frac = 16;
  localparam int unsigned Cw = 32;
  localparam int unsigned Latency = 120;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [31:0] r3;
    logic [1:0]  row;
    logic        last;
    logic [1:0]  status;
  } quat_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  func_i;
  logic [31:0] a_w_i, a_x_i, a_y_i, a_z_i;
  logic [31:0] b_w_i, b_x_i, b_y_i, b_z_i;
  logic        res_valid_o;
  logic [31:0] res_0_o, res_1_o, res_2_o, res_3_o;
  logic [1:0]  row_index_o;
  logic        last_o;
  logic [1:0]  status_o;

  int unsigned errors;
  int unsigned idle_cycles;

  // Mismatch report: one line per fault.
  task automatic report(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Fixed-point model of the unit and the queue of results still due.
  class QuatScoreboard;
    quat_result_t pending[$];

    // Saturate to the component width.
    function automatic longint clamp(longint v, ref bit sat);
      longint hi, lo;
      hi = (longint'(1) <<< (Cw - 1)) - 1;
      lo = -(longint'(1) <<< (Cw - 1));
      if (v > hi) begin
        sat = 1;
        return hi;
      end
      if (v < lo) begin
        sat = 1;
        return lo;
      end
      return v;
    endfunction

    // Exact sum of products divided by 2^s, rounded half up, saturated. The terms fit
    // comfortably in 128 bits, so an arithmetic shift of the total is exact.
    function automatic longint round_sum(logic signed [127:0] acc, int s, ref bit sat);
      logic signed [127:0] t;
      t = (acc + (128'sd1 <<< (s - 1))) >>> s;
      if (t > 128'sh7fffffff) begin
        sat = 1;
        return 64'sh7fffffff;
      end
      if (t < -128'sh80000000) begin
        sat = 1;
        return -64'sh80000000;
      end
      return longint'(t);
    endfunction

    function automatic logic signed [127:0] mul(longint p, longint q);
      return 128'(p) * 128'(q);
    endfunction

    // Floor square root of a wide unsigned value.
    function automatic logic [127:0] isqrt(logic [127:0] v);
      logic [127:0] root, bitv;
      root = 0;
      bitv = 128'd1 << 126;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function automatic void push(longint c0, longint c1, longint c2, longint c3,
                                 int row, bit lst, logic [1:0] st);
      quat_result_t e;
      e.r0 = c0[31:0];
      e.r1 = c1[31:0];
      e.r2 = c2[31:0];
      e.r3 = c3[31:0];
      e.row = row[1:0];
      e.last = lst;
      e.status = st;
      pending.push_back(e);
    endfunction

    // Note an accepted request and queue what it must produce.
    function automatic void note_request(logic [2:0] op, logic [31:0] av[4],
                                         logic [31:0] bv[4]);
      longint w, x, y, z, bw, bx, by, bz, c[4], one2;
      logic [127:0] sq, m, recip;
      logic signed [127:0] p;
      bit sat, s0, s1, s2;
      w = longint'(signed'(av[0]));
      x = longint'(signed'(av[1]));
      y = longint'(signed'(av[2]));
      z = longint'(signed'(av[3]));
      bw = longint'(signed'(bv[0]));
      bx = longint'(signed'(bv[1]));
      by = longint'(signed'(bv[2]));
      bz = longint'(signed'(bv[3]));
      sat = 0;
      s0 = 0;
      s1 = 0;
      s2 = 0;
      case (op)
        qau_pkg::OP_MUL: begin
          c[0] = round_sum(mul(w, bw) - mul(x, bx) - mul(y, by) - mul(z, bz), Frac, sat);
          c[1] = round_sum(mul(x, bw) + mul(w, bx) + mul(y, bz) - mul(z, by), Frac, sat);
          c[2] = round_sum(mul(y, bw) + mul(w, by) + mul(z, bx) - mul(x, bz), Frac, sat);
          c[3] = round_sum(mul(z, bw) + mul(w, bz) + mul(x, by) - mul(y, bx), Frac, sat);
          push(c[0], c[1], c[2], c[3], 0, 1, sat ? qau_pkg::StatusSat : qau_pkg::StatusOk);
        end
        qau_pkg::OP_VEC: begin
          c[0] = round_sum(-mul(x, bx) - mul(y, by) - mul(z, bz), Frac, sat);
          c[1] = round_sum(mul(w, bx) + mul(y, bz) - mul(z, by), Frac, sat);
          c[2] = round_sum(mul(w, by) + mul(z, bx) - mul(x, bz), Frac, sat);
          c[3] = round_sum(mul(w, bz) + mul(x, by) - mul(y, bx), Frac, sat);
          push(c[0], c[1], c[2], c[3], 0, 1, sat ? qau_pkg::StatusSat : qau_pkg::StatusOk);
        end
        qau_pkg::OP_CONJ: begin
          c[1] = clamp(-x, sat);
          c[2] = clamp(-y, sat);
          c[3] = clamp(-z, sat);
          push(w, c[1], c[2], c[3], 0, 1, sat ? qau_pkg::StatusSat : qau_pkg::StatusOk);
        end
        qau_pkg::OP_NORM: begin
          sq = mul(w, w) + mul(x, x) + mul(y, y) + mul(z, z);
          if (sq == 0) begin
            push(w, x, y, z, 0, 1, qau_pkg::StatusZero);
          end else begin
            m = isqrt(sq);
            recip = (128'd1 << (2 * Frac)) / m;
            c[0] = w;
            c[1] = x;
            c[2] = y;
            c[3] = z;
            for (int i = 0; i < 4; i++) begin
              p = mul(c[i], longint'(recip));
              c[i] = round_sum(p, Frac, sat);
            end
            push(c[0], c[1], c[2], c[3], 0, 1,
                 sat ? qau_pkg::StatusSat : qau_pkg::StatusOk);
          end
        end
        qau_pkg::OP_MAT: begin
          one2 = longint'(1) <<< (2 * Frac - 1);
          c[0] = round_sum(128'(one2) - mul(y, y) - mul(z, z), Frac - 1, s0);
          c[1] = round_sum(mul(x, y) - mul(w, z), Frac - 1, s0);
          c[2] = round_sum(mul(x, z) + mul(w, y), Frac - 1, s0);
          push(c[0], c[1], c[2], 0, 0, 0, s0 ? qau_pkg::StatusSat : qau_pkg::StatusOk);
          c[0] = round_sum(mul(x, y) + mul(w, z), Frac - 1, s1);
          c[1] = round_sum(128'(one2) - mul(x, x) - mul(z, z), Frac - 1, s1);
          c[2] = round_sum(mul(y, z) - mul(w, x), Frac - 1, s1);
          push(c[0], c[1], c[2], 0, 1, 0, s1 ? qau_pkg::StatusSat : qau_pkg::StatusOk);
          c[0] = round_sum(mul(x, z) - mul(w, y), Frac - 1, s2);
          c[1] = round_sum(mul(y, z) + mul(w, x), Frac - 1, s2);
          c[2] = round_sum(128'(one2) - mul(x, x) - mul(y, y), Frac - 1, s2);
          push(c[0], c[1], c[2], 0, 2, 0, s2 ? qau_pkg::StatusSat : qau_pkg::StatusOk);
          c[3] = clamp(longint'(1) <<< Frac, sat);
          push(0, 0, 0, c[3], 3, 1, sat ? qau_pkg::StatusSat : qau_pkg::StatusOk);
        end
        default: begin
          // Unknown selector: nothing comes back.
        end
      endcase
    endfunction

    // Compare one result with the oldest expectation.
    task automatic check_result(quat_result_t got);
      quat_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      e = pending.pop_front();
      if (got.r0 !== e.r0) report($sformatf("res_0 %h, want %h", got.r0, e.r0));
      if (got.r1 !== e.r1) report($sformatf("res_1 %h, want %h", got.r1, e.r1));
      if (got.r2 !== e.r2) report($sformatf("res_2 %h, want %h", got.r2, e.r2));
      if (got.r3 !== e.r3) report($sformatf("res_3 %h, want %h", got.r3, e.r3));
      if (got.row !== e.row) report($sformatf("row %0d, want %0d", got.row, e.row));
      if (got.last !== e.last) report($sformatf("last %0b, want %0b", got.last, e.last));
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
    endtask
  endclass

  QuatScoreboard quat_board;

  quaternion_arithmetic_unit_core DUT (.*);

  // Clock.
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Request acceptance and result checking at each rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        quat_board.note_request(func_i, '{a_w_i, a_x_i, a_y_i, a_z_i},
                                '{b_w_i, b_x_i, b_y_i, b_z_i});
      end
      if (res_valid_o) begin
        quat_board.check_result('{res_0_o, res_1_o, res_2_o, res_3_o,
                                  row_index_o, last_o, status_o});
      end
      if ((start_i && !busy_o) || res_valid_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if (idle_cycles > WatchLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Pick a component value, biased towards the edges.
  function automatic logic [31:0] pick_component(int kind);
    case (kind)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 131072)) - 65536);
      3: return 32'($signed($urandom_range(0, 8192)) - 4096);
      default: return $urandom;
    endcase
  endfunction

  // Send one request and hold it until accepted.
  task automatic send_request(logic [2:0] op, logic [31:0] av[4], logic [31:0] bv[4]);
    start_i <= 1;
    func_i <= op;
    a_w_i <= av[0];
    a_x_i <= av[1];
    a_y_i <= av[2];
    a_z_i <= av[3];
    b_w_i <= bv[0];
    b_x_i <= bv[1];
    b_y_i <= bv[2];
    b_z_i <= bv[3];
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic pause_sender(int cycles);
    start_i <= 0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Wait for every queued result, then idle so the unit drains.
  task automatic drain();
    start_i <= 0;
    while (quat_board.pending.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic random_request();
    logic [31:0] av[4], bv[4];
    int kind;
    int unsigned sel;
    logic [2:0] op;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      av[i] = pick_component(kind < 2 ? $urandom_range(0, 4) : $urandom_range(2, 4));
      bv[i] = pick_component(kind < 2 ? $urandom_range(0, 4) : $urandom_range(2, 4));
    end
    // Few normalize requests, as each holds the unit while it runs.
    sel = $urandom_range(0, 99);
    if (sel < 25) op = qau_pkg::OP_MUL;
    else if (sel < 45) op = qau_pkg::OP_VEC;
    else if (sel < 60) op = qau_pkg::OP_CONJ;
    else if (sel < 72) op = qau_pkg::OP_NORM;
    else if (sel < 95) op = qau_pkg::OP_MAT;
    else op = 3'($urandom_range(5, 7));
    if (op == qau_pkg::OP_NORM && $urandom_range(0, 7) == 0) av = '{0, 0, 0, 0};
    send_request(op, av, bv);
  endtask

  // Directed cases, then random bursts.
  initial begin
    logic [31:0] zq[4], mx[4], mn[4], one[4], half[4];
    int burst;
    errors = 0;
    quat_board = new();
    rst_ni = 0;
    start_i = 0;
    func_i = qau_pkg::OP_MUL;
    {a_w_i, a_x_i, a_y_i, a_z_i, b_w_i, b_x_i, b_y_i, b_z_i} = '0;
    zq = '{0, 0, 0, 0};
    mx = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    mn = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    one = '{32'h0001_0000, 0, 0, 0};
    half = '{32'h0000_8000, 32'hffff_8000, 32'h0000_8000, 32'hffff_8000};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_request(qau_pkg::OP_MUL, one, half);
    send_request(qau_pkg::OP_MUL, mx, mn);
    send_request(qau_pkg::OP_MUL, mn, mn);
    send_request(qau_pkg::OP_VEC, half, mx);
    send_request(qau_pkg::OP_VEC, mn, mx);
    send_request(qau_pkg::OP_CONJ, mn, zq);
    send_request(qau_pkg::OP_CONJ, mx, zq);
    send_request(qau_pkg::OP_CONJ, half, zq);
    send_request(qau_pkg::OP_NORM, zq, zq);
    send_request(qau_pkg::OP_NORM, one, zq);
    send_request(qau_pkg::OP_NORM, mn, zq);
    send_request(qau_pkg::OP_NORM, mx, zq);
    send_request(qau_pkg::OP_NORM, '{1, 0, 0, 0}, zq);
    send_request(qau_pkg::OP_MAT, one, zq);
    send_request(qau_pkg::OP_MAT, mx, zq);
    send_request(qau_pkg::OP_MAT, mn, zq);
    send_request(qau_pkg::OP_MAT, half, zq);
    send_request(3'd5, mx, mx);
    send_request(3'd7, mn, mn);
    send_request(qau_pkg::OP_MUL, '{$urandom, $urandom, $urandom, $urandom},
                 '{$urandom, $urandom, $urandom, $urandom});
    drain();

    // Random bursts; at least one drain midway as a full pause.
    for (int n = 0; n < 340; n += burst) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++) random_request();
      if (n > 150 && n < 165) drain();
      else if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 20));
    end
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
